// File: rtl/core/rgbhsl_pkg.sv
// Shared codes and constants for the RGB to HSL pixel converter.
package rgbhsl_pkg;

	localparam logic [1:0] SECT_RED   = 2'd0;
	localparam logic [1:0] SECT_GREEN = 2'd1;
	localparam logic [1:0] SECT_BLUE  = 2'd2;

	localparam int HUE_GREEN_OFS = 2;
	localparam int HUE_BLUE_OFS  = 4;
	localparam int HUE_TURN      = 6;

	localparam int BYTE_BITS = 8;

endpackage

// File: rtl/core/rgb_to_hsl_pixel_core.sv
// Top level of the RGB to HSL pixel converter.
//
// Takes one RGB pixel per clock while the output is not stalled and returns hue,
// saturation and lightness (max+min) for it, one result per pixel, in order.
// Throughput is one pixel per cycle when not stalled: two stages find max, min,
// delta and the sector, then a restoring divider produces one quotient bit
// per stage for hue and saturation side by side. Every stage holds its beat
// independently, so a stalled output only backs up full stages and the
// input keeps taking beats while there is an empty stage anywhere ahead.
module rgb_to_hsl_pixel_core
	import rgbhsl_pkg::*;
#(
	parameter int COMPONENT_BITS = 8,
	parameter int FRACTION_BITS  = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// red, green, blue
	input  logic [((3*COMPONENT_BITS+BYTE_BITS-1)/BYTE_BITS)*BYTE_BITS-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// hue, saturation, lightness
	output logic [((2*FRACTION_BITS+COMPONENT_BITS+1+BYTE_BITS-1)/BYTE_BITS)*BYTE_BITS-1:0]
		m_axis_tdata
);

	localparam int CB       = COMPONENT_BITS;
	localparam int F        = FRACTION_BITS;
	localparam int DW       = CB + 3;
	localparam int LW       = CB + 1;
	localparam int NW       = CB + F;
	localparam int OUT_FLDS = 2*F + LW;
	localparam int OUT_W    = ((OUT_FLDS + BYTE_BITS - 1) / BYTE_BITS) * BYTE_BITS;

	localparam logic [LW-1:0] CMAX_L   = {1'b0, {CB{1'b1}}};
	localparam logic [LW-1:0] TWO_CMAX = {{CB{1'b1}}, 1'b0};
	localparam logic [DW-1:0] ONE_D    = DW'(1);

	logic [CB-1:0] red, green, blue;
	logic [CB-1:0] top_d, bot_d;
	logic [1:0]    sector_d;

	logic          v_s1, rdy_s1;
	logic [CB-1:0] red_s1, green_s1, blue_s1, top_s1, bot_s1;
	logic [1:0]    sector_s1;

	logic [CB-1:0] delta;
	logic [LW-1:0] sum;
	logic          grey;
	logic [DW-1:0] dx, rx, gx, bx, six_d, num;
	logic [CB-1:0] den_sat;
	logic [NW-1:0] sat_prod;

	logic                  v_s2, rdy_s2;
	logic [1:0][DW-1:0]    hi_s2, den_s2;
	logic [1:0][F-1:0]     lo_s2;
	logic [LW-1:0]         light_s2;

	logic                  div_ready;
	logic [1:0][F-1:0]     quot;
	logic [LW-1:0]         light_out;

	assign red   = s_axis_tdata[CB-1:0];
	assign green = s_axis_tdata[2*CB-1:CB];
	assign blue  = s_axis_tdata[3*CB-1:2*CB];

	always_comb begin
		top_d = red;
		bot_d = red;
		if (green > top_d) top_d = green;
		if (blue > top_d)  top_d = blue;
		if (green < bot_d) bot_d = green;
		if (blue < bot_d)  bot_d = blue;
		if (red >= green && red >= blue) begin
			sector_d = SECT_RED;
		end else if (green >= blue) begin
			sector_d = SECT_GREEN;
		end else begin
			sector_d = SECT_BLUE;
		end
	end

	assign rdy_s1        = ~v_s1 | rdy_s2;
	assign rdy_s2        = ~v_s2 | div_ready;
	assign s_axis_tready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= s_axis_tvalid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			red_s1    <= red;
			green_s1  <= green;
			blue_s1   <= blue;
			top_s1    <= top_d;
			bot_s1    <= bot_d;
			sector_s1 <= sector_d;
		end
	end

	always_comb begin
		delta    = top_s1 - bot_s1;
		sum      = {1'b0, top_s1} + {1'b0, bot_s1};
		grey     = (delta == '0);
		dx       = DW'(delta);
		rx       = DW'(red_s1);
		gx       = DW'(green_s1);
		bx       = DW'(blue_s1);
		six_d    = DW'(dx * HUE_TURN);
		case (sector_s1)
			SECT_RED: begin
				num = (green_s1 >= blue_s1) ? (gx - bx) : (six_d - (bx - gx));
			end
			SECT_GREEN: begin
				num = DW'(dx * HUE_GREEN_OFS) + bx - rx;
			end
			SECT_BLUE: begin
				num = DW'(dx * HUE_BLUE_OFS) + rx - gx;
			end
			default: begin
				num = '0;
			end
		endcase
		if (sum <= CMAX_L) begin
			den_sat = sum[CB-1:0];
		end else begin
			den_sat = CB'(TWO_CMAX - sum);
		end
		sat_prod = {delta, {F{1'b0}}} - NW'(delta);
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			hi_s2[0]  <= grey ? '0 : num;
			lo_s2[0]  <= '0;
			den_s2[0] <= grey ? ONE_D : six_d;
			hi_s2[1]  <= DW'(sat_prod[NW-1:F]);
			lo_s2[1]  <= sat_prod[F-1:0];
			den_s2[1] <= grey ? ONE_D : DW'(den_sat);
			light_s2  <= sum;
		end
	end

	rgbhsl_div #(
		.DW    (DW),
		.QW    (F),
		.SW    (LW),
		.LANES (2)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_ready  (div_ready),
		.in_hi     (hi_s2),
		.in_lo     (lo_s2),
		.in_den    (den_s2),
		.in_side   (light_s2),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_quot  (quot),
		.out_side  (light_out)
	);

	assign m_axis_tdata = OUT_W'({light_out, quot[1], quot[0]});

`ifndef NO_ASSERTIONS
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (hi_s2[0] < den_s2[0]) && (hi_s2[1] < den_s2[1]))
		else $error("divider operand not below divisor");

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> s_axis_tready)
		else $error("empty front stage refused a beat");

	a_light_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[2*F+LW-1:2*F] <= TWO_CMAX))
		else $error("lightness out of range");

	a_black_grey: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[2*F+LW-1:2*F] == '0)
		|-> (m_axis_tdata[2*F-1:0] == '0))
		else $error("black pixel with nonzero hue or saturation");
`endif

endmodule

// File: rtl/core/rgbhsl_div.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes in lockstep.
module rgbhsl_div #(
	parameter int DW    = 11,
	parameter int QW    = 16,
	parameter int SW    = 9,
	parameter int LANES = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [LANES-1:0][DW-1:0]     in_hi,
	input  logic [LANES-1:0][QW-1:0]     in_lo,
	input  logic [LANES-1:0][DW-1:0]     in_den,
	input  logic [SW-1:0]                in_side,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [LANES-1:0][QW-1:0]     out_quot,
	output logic [SW-1:0]                out_side
);

	logic [QW-1:0]               v_s;
	logic [QW:0]                 rdy;
	logic [LANES-1:0][DW-1:0]    rem_s  [QW];
	logic [LANES-1:0][QW-1:0]    acc_s  [QW];
	logic [LANES-1:0][DW-1:0]    den_s  [QW];
	logic [SW-1:0]               side_s [QW];

	assign rdy[QW] = out_ready;

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic                      valid_i;
		logic [LANES-1:0][DW-1:0]  rem_i;
		logic [LANES-1:0][QW-1:0]  acc_i;
		logic [LANES-1:0][DW-1:0]  den_i;
		logic [SW-1:0]             side_i;
		logic [LANES-1:0][DW-1:0]  rem_n;
		logic [LANES-1:0][QW-1:0]  acc_n;

		if (k == 0) begin : g_first
			assign valid_i = in_valid;
			assign rem_i   = in_hi;
			assign acc_i   = in_lo;
			assign den_i   = in_den;
			assign side_i  = in_side;
		end else begin : g_next
			assign valid_i = v_s[k-1];
			assign rem_i   = rem_s[k-1];
			assign acc_i   = acc_s[k-1];
			assign den_i   = den_s[k-1];
			assign side_i  = side_s[k-1];
		end

		assign rdy[k] = ~v_s[k] | rdy[k+1];

		always_comb begin
			logic [DW:0] t;
			logic [DW:0] diff;
			logic        ge;
			for (int l = 0; l < LANES; l++) begin
				t        = {rem_i[l], acc_i[l][QW-1]};
				diff     = t - {1'b0, den_i[l]};
				ge       = (t >= {1'b0, den_i[l]});
				rem_n[l] = ge ? diff[DW-1:0] : t[DW-1:0];
				acc_n[l] = {acc_i[l][QW-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_s[k] <= valid_i;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				rem_s[k]  <= rem_n;
				acc_s[k]  <= acc_n;
				den_s[k]  <= den_i;
				side_s[k] <= side_i;
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = v_s[QW-1];
	assign out_quot  = acc_s[QW-1];
	assign out_side  = side_s[QW-1];

endmodule

// File: test/tb.sv
// Self-checking testbench for the RGB to HSL pixel converter core.
module tb
	import rgbhsl_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int COMPONENT_BITS = 8;
	localparam int FRACTION_BITS = 16;
	localparam int IN_W = ((3 * COMPONENT_BITS + BYTE_BITS - 1) / BYTE_BITS) * BYTE_BITS;
	localparam int OUT_W =
		((2 * FRACTION_BITS + COMPONENT_BITS + 1 + BYTE_BITS - 1) / BYTE_BITS) * BYTE_BITS;
	localparam int LATENCY = FRACTION_BITS + 2;
	localparam int DRAIN_LIMIT = 20000;
	localparam int RANDOM_PER_PHASE = 560;
	localparam logic [63:0] COMP_MAX = (64'd1 << COMPONENT_BITS) - 1;
	localparam logic [63:0] FRAC_MAX = (64'd1 << FRACTION_BITS) - 1;

	typedef struct packed {
		logic [COMPONENT_BITS-1:0] red;
		logic [COMPONENT_BITS-1:0] green;
		logic [COMPONENT_BITS-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [FRACTION_BITS-1:0]  hue;
		logic [FRACTION_BITS-1:0]  sat;
		logic [COMPONENT_BITS:0]   light;
	} hsl_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata = '0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;

	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   error_count = 0;
	int   checked_count = 0;
	hsl_t pending_hsl[$];

	rgb_to_hsl_pixel_core #(
		.COMPONENT_BITS(COMPONENT_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #5 clk = ~clk;

	function automatic hsl_t rgb_to_hsl(input rgb_t px);
		logic [63:0] r, g, b, hi, lo, delta, sum, den, num, q;
		hsl_t res;
		r = px.red;
		g = px.green;
		b = px.blue;
		hi = r;
		lo = r;
		if (g > hi) hi = g;
		if (b > hi) hi = b;
		if (g < lo) lo = g;
		if (b < lo) lo = b;
		delta = hi - lo;
		sum = hi + lo;
		res.hue = '0;
		res.sat = '0;
		res.light = sum[COMPONENT_BITS:0];
		if (delta != 0) begin
			if (hi == r) begin
				if (g >= b) num = g - b;
				else num = HUE_TURN * delta - (b - g);
			end else if (hi == g) begin
				num = HUE_GREEN_OFS * delta + b - r;
			end else begin
				num = HUE_BLUE_OFS * delta + r - g;
			end
			q = (num << FRACTION_BITS) / (HUE_TURN * delta);
			res.hue = (q > FRAC_MAX) ? FRAC_MAX[FRACTION_BITS-1:0] : q[FRACTION_BITS-1:0];
			den = (sum <= COMP_MAX) ? sum : 2 * COMP_MAX - sum;
			if (den != 0) begin
				q = (delta * FRAC_MAX) / den;
				res.sat = (q > FRAC_MAX) ? FRAC_MAX[FRACTION_BITS-1:0] : q[FRACTION_BITS-1:0];
			end else begin
				res.sat = FRAC_MAX[FRACTION_BITS-1:0];
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= 50)
			$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	// Enter and leave at a falling edge.
	task automatic send_pixel(input rgb_t px);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_W'({px.blue, px.green, px.red});
		do @(posedge clk); while (!s_axis_tready);
		pending_hsl.push_back(rgb_to_hsl(px));
		@(negedge clk);
	endtask

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin : check_results
		hsl_t want, got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.hue = m_axis_tdata[FRACTION_BITS-1:0];
			got.sat = m_axis_tdata[2*FRACTION_BITS-1:FRACTION_BITS];
			got.light = m_axis_tdata[2*FRACTION_BITS+COMPONENT_BITS:2*FRACTION_BITS];
			if (pending_hsl.size() == 0) begin
				report_mismatch("result beat with no pixel pending");
			end else begin
				want = pending_hsl.pop_front();
				checked_count++;
				if (got.hue !== want.hue)
					report_mismatch($sformatf("hue got %0d want %0d", got.hue, want.hue));
				if (got.sat !== want.sat)
					report_mismatch($sformatf("saturation got %0d want %0d",
						got.sat, want.sat));
				if (got.light !== want.light)
					report_mismatch($sformatf("lightness got %0d want %0d",
						got.light, want.light));
			end
		end
	end

	function automatic rgb_t make_rgb(input int r, input int g, input int b);
		rgb_t px;
		px.red = r[COMPONENT_BITS-1:0];
		px.green = g[COMPONENT_BITS-1:0];
		px.blue = b[COMPONENT_BITS-1:0];
		return px;
	endfunction

	function automatic int pick_extreme();
		case ($urandom_range(2))
			0: return 0;
			1: return int'(COMP_MAX);
			default: return $urandom_range(int'(COMP_MAX));
		endcase
	endfunction

	function automatic rgb_t random_pixel();
		int a, d;
		a = $urandom_range(int'(COMP_MAX));
		case ($urandom_range(9))
			0: return make_rgb(a, a, a);
			1: begin
				d = $urandom_range(int'(COMP_MAX));
				case ($urandom_range(2))
					0: return make_rgb(a, a, d);
					1: return make_rgb(d, a, a);
					default: return make_rgb(a, d, a);
				endcase
			end
			2: begin
				d = int'(COMP_MAX) - 2;
				if (a > d) a = d;
				return make_rgb(a + $urandom_range(2), a + $urandom_range(2),
					a + $urandom_range(2));
			end
			3: return make_rgb(pick_extreme(), pick_extreme(), pick_extreme());
			default: return make_rgb($urandom, $urandom, $urandom);
		endcase
	endfunction

	task automatic test_grey_and_extremes();
		send_pixel(make_rgb(0, 0, 0));
		send_pixel(make_rgb(255, 255, 255));
		send_pixel(make_rgb(128, 128, 128));
		send_pixel(make_rgb(1, 0, 0));
		send_pixel(make_rgb(0, 1, 0));
		send_pixel(make_rgb(0, 0, 1));
		send_pixel(make_rgb(255, 254, 254));
		send_pixel(make_rgb(254, 255, 255));
		send_pixel(make_rgb(128, 127, 127));
	endtask

	task automatic test_sectors_and_ties();
		send_pixel(make_rgb(255, 0, 0));
		send_pixel(make_rgb(0, 255, 0));
		send_pixel(make_rgb(0, 0, 255));
		send_pixel(make_rgb(255, 255, 0));
		send_pixel(make_rgb(0, 255, 255));
		send_pixel(make_rgb(255, 0, 255));
		send_pixel(make_rgb(255, 0, 1));
		send_pixel(make_rgb(255, 1, 0));
		send_pixel(make_rgb(255, 128, 0));
		send_pixel(make_rgb(200, 100, 50));
		send_pixel(make_rgb(50, 200, 100));
		send_pixel(make_rgb(100, 50, 200));
	endtask

	task automatic test_random_pixels(input int count);
		repeat (count) send_pixel(random_pixel());
	endtask

	initial begin : main
		int waited;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 28;
		recv_idle_pct = 62;
		test_grey_and_extremes();
		test_sectors_and_ties();
		test_random_pixels(RANDOM_PER_PHASE);

		send_idle_pct = 62;
		recv_idle_pct = 28;
		test_random_pixels(RANDOM_PER_PHASE);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_pixels(RANDOM_PER_PHASE);
		s_axis_tvalid <= 1'b0;

		waited = 0;
		while (pending_hsl.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		while (pending_hsl.size() != 0) begin
			void'(pending_hsl.pop_front());
			report_mismatch("expected result never arrived");
		end
		repeat (4 * LATENCY) @(negedge clk);

		$display("Converted %0d pixels (grey, extremes, every hue sector and max ties,",
			checked_count);
		$display("then random pixels) under three handshake pacing mixes.");
		if (error_count == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

	initial begin : watchdog
		#2ms;
		$display("tb: errors");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/rgbhsl_pkg.sv
rtl/core/rgbhsl_div.sv
rtl/core/rgb_to_hsl_pixel_core.sv
test/tb.sv
